>>> rtl/core/tpq_pkg.sv
// Shared types and codes for the timed priority transmit slot queue.
package tpq_pkg;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_SEL = 2'd1,
    MODE_REL = 2'd2,
    MODE_CLR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_NO_PAYLOAD = 3'd2,
    ST_FULL       = 3'd3,
    ST_NONE_READY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_SCAN,
    S_SEL_SCAN,
    S_SEL_DRAIN,
    S_FINISH
  } state_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [7:0]  len;
    logic [31:0] sched;
    logic [7:0]  prio;
  } slot_entry_t;

  // Control from the sequencer to the selection unit.
  typedef struct packed {
    logic start;     // forget the current pick
    logic rd_valid;  // read data belongs to an active slot
  } pick_ctl_t;

endpackage

>>> rtl/core/tpq_slot_mem.sv
// Slot record memory: one write port, one read port with registered read data.
module tpq_slot_mem
  import tpq_pkg::*;
#(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/tpq_pick.sv
// Selection unit: keeps the best due slot seen so far during a select scan.
module tpq_pick
  import tpq_pkg::*;
#(
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  pick_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  slot_entry_t      entry,
  input  logic [31:0]      now,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output slot_entry_t      best
);

  logic [31:0] now_diff;
  logic [31:0] best_diff;
  logic        due;
  logic        better;

  // Both differences are read as signed 32-bit values so that the tick count may wrap.
  always_comb begin
    now_diff  = now - entry.sched;
    best_diff = best.sched - entry.sched;
    due       = !now_diff[31];
    better    = !found || (entry.prio < best.prio) ||
                ((entry.prio == best.prio) && !best_diff[31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (ctl.rd_valid && due && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_valid && due && better) begin
      best_idx <= idx;
      best     <= entry;
    end
  end

endmodule

>>> rtl/core/timed_priority_tx_slot_queue.sv
// Top level of the timed priority transmit slot queue: sequencer, slot flags and result register.
//
// One input transaction (in_valid/in_ready) carries one command: enqueue, select, release or
// clear. Each command yields exactly one result transaction (out_valid/out_ready) with the
// status, the chosen slot (and, for a select, its record), and the active count after the command.
// Slot records live in a single-port-read memory; active flags and the count are flip-flops.
// Commands run one at a time; in_ready is high while the sequencer is idle.
// Steps from acceptance to the result, with the receiver ready:
//   release, clear and a rejected enqueue: straight to the finish state;
//   enqueue into slot k: slots 0 to k are scanned (one active flag is examined per cycle);
//   select: every slot is read (one memory read per slot), then a drain state covers the read latency.
// The next command can be accepted from the cycle after its predecessor's result is registered.
// A result waits in the output register while out_ready is low; the next command may be
// accepted meanwhile, and its result is held back until the register is free.
// Reset marks every slot free, empties the output register and returns to idle; the record
// memory is not cleared because the records of free slots are never reported.
module timed_priority_tx_slot_queue
  import tpq_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int MAX_LEN    = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [9:0]  length,
  input  logic        payload_given,
  input  logic [31:0] sched_time,
  input  logic [7:0]  prio,
  input  logic [31:0] now_time,
  input  logic [2:0]  slot_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [2:0]  slot_out,
  output logic [7:0]  out_length,
  output logic [31:0] out_time,
  output logic [7:0]  out_prio,
  output logic [3:0]  active_count,
  output logic        queue_empty
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_t                  state, state_next;
  logic [SLOT_COUNT-1:0]   active;
  logic [CNT_W-1:0]        cnt;
  logic [IDX_W-1:0]        scan_idx;
  mode_t                   op_mode;
  logic [7:0]              op_len;
  logic [31:0]             op_sched;
  logic [7:0]              op_prio;
  logic [31:0]             op_now;
  status_t                 res_status;
  logic [IDX_W-1:0]        res_slot;
  logic                    rd_pending;
  logic                    rd_active;
  logic [IDX_W-1:0]        rd_idx;
  logic                    wr_en;
  logic                    rd_en;
  slot_entry_t             wr_data;
  slot_entry_t             rd_data;
  pick_ctl_t               pick_ctl;
  logic                    best_found;
  logic [IDX_W-1:0]        best_idx;
  slot_entry_t             best;
  logic                    in_accept;
  logic                    out_load;
  logic                    free_here;
  logic                    sel_in_range;
  logic [IDX_W-1:0]        sel_idx;
  logic                    too_long;
  logic                    no_payload;

  assign in_ready     = (state == S_IDLE);
  assign in_accept    = in_valid && in_ready;
  assign out_load     = (state == S_FINISH) && (!out_valid || out_ready);
  assign free_here    = !active[scan_idx];
  assign sel_idx      = IDX_W'(slot_sel);
  assign sel_in_range = (int'(slot_sel) < SLOT_COUNT);
  assign too_long     = (int'(length) > MAX_LEN);
  assign no_payload   = (length != 10'd0) && !payload_given;
  assign wr_data      = '{len: op_len, sched: op_sched, prio: op_prio};

  assign pick_ctl.start    = in_accept && (mode_t'(mode) == MODE_SEL);
  assign pick_ctl.rd_valid = rd_pending && rd_active;

  tpq_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (scan_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  tpq_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pick_ctl),
    .idx      (rd_idx),
    .entry    (rd_data),
    .now      (op_now),
    .found    (best_found),
    .best_idx (best_idx),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (mode_t'(mode))
            MODE_ENQ: state_next = (too_long || no_payload) ? S_FINISH : S_ENQ_SCAN;
            MODE_SEL: state_next = S_SEL_SCAN;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_ENQ_SCAN: begin
        if (free_here) begin
          wr_en      = 1'b1;
          state_next = S_FINISH;
        end else if (scan_idx == LAST_IDX) begin
          state_next = S_FINISH;
        end
      end
      S_SEL_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx == LAST_IDX) begin
          state_next = S_SEL_DRAIN;
        end
      end
      S_SEL_DRAIN: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Slot flags, active count and handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      cnt        <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (in_accept) begin
        case (mode_t'(mode))
          MODE_REL: begin
            if (sel_in_range && active[sel_idx]) begin
              active[sel_idx] <= 1'b0;
              cnt             <= cnt - 1'b1;
            end
          end
          MODE_CLR: begin
            active <= '0;
            cnt    <= '0;
          end
          default: ;
        endcase
      end
      if (wr_en) begin
        active[scan_idx] <= 1'b1;
        cnt              <= cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command operands, scan position and result register.
  always_ff @(posedge clk) begin
    rd_idx    <= scan_idx;
    rd_active <= active[scan_idx];
    if (in_accept) begin
      op_mode  <= mode_t'(mode);
      op_len   <= length[7:0];
      op_sched <= sched_time;
      op_prio  <= prio;
      op_now   <= now_time;
      scan_idx <= '0;
      res_slot <= '0;
      if (mode_t'(mode) == MODE_ENQ && too_long) begin
        res_status <= ST_TOO_LONG;
      end else if (mode_t'(mode) == MODE_ENQ && no_payload) begin
        res_status <= ST_NO_PAYLOAD;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (state == S_ENQ_SCAN) begin
      if (free_here) begin
        res_slot <= scan_idx;
      end else if (scan_idx == LAST_IDX) begin
        res_status <= ST_FULL;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (state == S_SEL_SCAN && scan_idx != LAST_IDX) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (out_load) begin
      active_count <= 4'(cnt);
      queue_empty  <= (cnt == '0);
      if (op_mode == MODE_SEL) begin
        if (best_found) begin
          status     <= ST_OK;
          slot_out   <= 3'(best_idx);
          out_length <= best.len;
          out_time   <= best.sched;
          out_prio   <= best.prio;
        end else begin
          status     <= ST_NONE_READY;
          slot_out   <= '0;
          out_length <= '0;
          out_time   <= '0;
          out_prio   <= '0;
        end
      end else begin
        status     <= res_status;
        slot_out   <= 3'(res_slot);
        out_length <= '0;
        out_time   <= '0;
        out_prio   <= '0;
      end
    end
  end

  // The running count must always agree with the slot flags.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    cnt == CNT_W'($countones(active)))
    else $error("active count disagrees with slot flags");

  // The sequencer is busy in the cycle after a command is accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("second command accepted while busy");

  // Memory read data only returns during a select scan.
  a_read_in_select: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == S_SEL_SCAN || state == S_SEL_DRAIN))
    else $error("memory read outside a select scan");

  // A clear leaves no slot active.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode_t'(mode) == MODE_CLR) |=> (cnt == '0 && active == '0))
    else $error("clear left active slots");

endmodule
